// ----- rtl/mi3_pkg.sv -----
// Package: shared types, constants and helpers for the 3x3 matrix inverse.
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int ElemW  = 24;
  localparam int CofW   = 49;
  localparam int DetW   = 73;
  localparam int DmagW  = 72;
  localparam int DetOutW = 48;
  localparam int QW     = 25;
  localparam int LaneSt = QW + 1;
  localparam int NumSt  = 4 + LaneSt + 1;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [CofW-1:0]  cof_t;

  typedef struct packed {
    logic [QW-1:0] q;
    logic          sat;
    logic          neg;
  } mi3_quot_t;

  function automatic logic [ElemW-1:0] quot_sat(mi3_quot_t r);
    logic [QW:0] mag;
    logic [QW:0] neg_mag;
    mag = r.sat ? {1'b1, {QW{1'b0}}} : {1'b0, r.q};
    neg_mag = -mag;
    if (r.neg) begin
      if (mag > (QW+1)'(24'h800000)) quot_sat = 24'h800000;
      else quot_sat = neg_mag[ElemW-1:0];
    end else begin
      if (mag > (QW+1)'(24'h7FFFFF)) quot_sat = 24'h7FFFFF;
      else quot_sat = mag[ElemW-1:0];
    end
  endfunction

endpackage

// ----- rtl/mi3_cof_lane.sv -----
// One cofactor lane: two products, difference, sign.
`timescale 1ns / 1ps
module mi3_cof_lane #(
  parameter bit NEG = 1'b0
) (
  input  logic                 clk,
  input  logic [1:0]           en,
  input  mi3_pkg::elem_t       x0,
  input  mi3_pkg::elem_t       y0,
  input  mi3_pkg::elem_t       x1,
  input  mi3_pkg::elem_t       y1,
  output mi3_pkg::cof_t        cof
);
  import mi3_pkg::*;

  logic signed [2*ElemW-1:0] p0;
  logic signed [2*ElemW-1:0] p1;
  logic signed [CofW-1:0]    diff;

  assign diff = {p0[2*ElemW-1], p0} - {p1[2*ElemW-1], p1};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0 <= x0 * y0;
      p1 <= x1 * y1;
    end
    if (en[1]) begin
      cof <= NEG ? -diff : diff;
    end
  end

endmodule

// ----- rtl/mi3_det.sv -----
// Determinant merge: row 0 times cofactors, summed, with magnitude and sign.
`timescale 1ns / 1ps
module mi3_det (
  input  logic                   clk,
  input  logic [1:0]             en,
  input  mi3_pkg::elem_t         a [0:2],
  input  mi3_pkg::cof_t          c [0:2],
  output logic [mi3_pkg::DetW-1:0]  det,
  output logic [mi3_pkg::DmagW-1:0] dmag,
  output logic                   dneg,
  output logic                   zero
);
  import mi3_pkg::*;

  logic signed [2*ElemW-1:0] ph [0:2];
  logic signed [2*ElemW+1:0] pl [0:2];
  logic [DetW-1:0]           sum;
  logic [DetW-1:0]           nsum;

  always_comb begin
    sum = '0;
    for (int j = 0; j < 3; j++) begin
      sum = sum + {ph[j], 25'b0} + {{(DetW-2*ElemW-2){pl[j][2*ElemW+1]}}, pl[j]};
    end
    nsum = -sum;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      if (en[0]) begin
        ph[j] <= a[j] * $signed(c[j][CofW-1:25]);
        pl[j] <= a[j] * $signed({1'b0, c[j][24:0]});
      end
    end
    if (en[1]) begin
      det  <= sum;
      dneg <= sum[DetW-1];
      dmag <= sum[DetW-1] ? nsum[DmagW-1:0] : sum[DmagW-1:0];
      zero <= (sum == '0);
    end
  end

endmodule

// ----- rtl/mi3_div_lane.sv -----
// Divider lane: pipelined restoring division of |cof|*2^32 by |det|, one bit per stage.
`timescale 1ns / 1ps
module mi3_div_lane (
  input  logic                      clk,
  input  logic [mi3_pkg::LaneSt-1:0] en,
  input  mi3_pkg::cof_t             cof,
  input  logic [mi3_pkg::DmagW-1:0] dmag,
  input  logic                      dneg,
  output mi3_pkg::mi3_quot_t        res
);
  import mi3_pkg::*;

  localparam int RemW = CofW - 1 + 32;
  localparam int CmpW = DmagW + QW;

  logic [RemW-1:0]  rem [0:LaneSt-1];
  logic [QW-1:0]    q   [0:LaneSt-1];
  logic [DmagW-1:0] dm  [0:LaneSt-1];
  logic             ng  [0:LaneSt-1];
  logic             st  [0:LaneSt-1];

  logic [CofW-1:0]  ncof;
  logic [CofW-2:0]  mag;
  logic [CmpW-1:0]  num;

  assign ncof = -cof;
  assign mag  = cof[CofW-1] ? ncof[CofW-2:0] : cof[CofW-2:0];
  assign num  = {{(CmpW-RemW){1'b0}}, mag, 32'b0};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0] <= {mag, 32'b0};
      q[0]   <= '0;
      dm[0]  <= dmag;
      ng[0]  <= cof[CofW-1] ^ dneg;
      st[0]  <= num >= {dmag, {QW{1'b0}}};
    end
  end

  for (genvar k = 1; k < LaneSt; k++) begin : g_step
    localparam int B = QW - k;
    logic [CmpW-1:0] t;
    logic            ge;
    logic [QW-1:0]   q_next;

    assign t  = {{QW{1'b0}}, dm[k-1]} << B;
    assign ge = {{(CmpW-RemW){1'b0}}, rem[k-1]} >= t;

    always_comb begin
      q_next    = q[k-1];
      q_next[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k] <= ge ? rem[k-1] - t[RemW-1:0] : rem[k-1];
        q[k]   <= q_next;
        dm[k]  <= dm[k-1];
        ng[k]  <= ng[k-1];
        st[k]  <= st[k-1];
      end
    end
  end

  assign res.q   = q[LaneSt-1];
  assign res.sat = st[LaneSt-1];
  assign res.neg = ng[LaneSt-1];

endmodule

// ----- rtl/matrix3_inverse_top.sv -----
// Top level: 3x3 matrix inverse and determinant, one matrix per cycle unless stalled.
//
//  channel | direction | handshake              | payload
//  mat     | in        | mat_valid / mat_stall  | a00 .. a22
//  inv     | out       | inv_valid / inv_stall  | inv00 .. inv22, determinant, singular
//
// An accepted item passes through 31 register stages to the output; one item
// enters per cycle while mat_stall is low. The depth is set by the 26-stage quotient
// pipeline: a setup stage, then one quotient bit per stage in each of nine lanes.
// Reset clears only the valid bits of the stages.
// A stalled output holds; bubbles inside close up, so items keep entering
// until every stage is full.
`timescale 1ns / 1ps
module matrix3_inverse_top (
  input  logic clk,
  input  logic rst,
  input  logic mat_valid,
  output logic mat_stall,
  input  mi3_pkg::elem_t a00, a01, a02, a10, a11, a12, a20, a21, a22,
  output logic inv_valid,
  input  logic inv_stall,
  output mi3_pkg::elem_t inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
  output logic signed [mi3_pkg::DetOutW-1:0] determinant,
  output logic singular
);
  import mi3_pkg::*;

  logic [NumSt+1:1] rdy;
  logic [NumSt:0]   v;

  elem_t a [0:8];
  elem_t r0d1 [0:2];
  elem_t r0d2 [0:2];
  cof_t  cof [0:8];
  cof_t  c3  [0:8];
  cof_t  c4  [0:8];
  mi3_quot_t qr [0:8];

  logic [DetW-1:0]  det;
  logic [DmagW-1:0] dmag;
  logic             dneg;
  logic             zero;

  logic [DetOutW-1:0] dline [0:LaneSt-1];
  logic               zline [0:LaneSt-1];
  logic [ElemW-1:0]   inv_next [0:8];

  assign a[0] = a00; assign a[1] = a01; assign a[2] = a02;
  assign a[3] = a10; assign a[4] = a11; assign a[5] = a12;
  assign a[6] = a20; assign a[7] = a21; assign a[8] = a22;

  assign v[0] = mat_valid;
  assign rdy[NumSt+1] = !inv_stall;
  for (genvar k = 1; k <= NumSt; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= v[k-1];
      end
    end
  end
  assign mat_stall = !rdy[1];
  assign inv_valid = v[NumSt];

  for (genvar r = 0; r < 3; r++) begin : g_r
    for (genvar c = 0; c < 3; c++) begin : g_c
      localparam int R0 = (r > 0) ? 0 : 1;
      localparam int R1 = (r < 2) ? 2 : 1;
      localparam int C0 = (c > 0) ? 0 : 1;
      localparam int C1 = (c < 2) ? 2 : 1;
      mi3_cof_lane #(.NEG(((r + c) % 2) == 1)) u_cof (
        .clk (clk),
        .en  (rdy[2:1]),
        .x0  (a[R0*3+C0]),
        .y0  (a[R1*3+C1]),
        .x1  (a[R0*3+C1]),
        .y1  (a[R1*3+C0]),
        .cof (cof[r*3+c])
      );
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      if (rdy[1]) r0d1[j] <= a[j];
      if (rdy[2]) r0d2[j] <= r0d1[j];
    end
    for (int j = 0; j < 9; j++) begin
      if (rdy[3]) c3[j] <= cof[j];
      if (rdy[4]) c4[j] <= c3[j];
    end
  end

  mi3_det u_det (
    .clk  (clk),
    .en   (rdy[4:3]),
    .a    (r0d2),
    .c    (cof[0:2]),
    .det  (det),
    .dmag (dmag),
    .dneg (dneg),
    .zero (zero)
  );

  for (genvar i = 0; i < 3; i++) begin : g_ir
    for (genvar j = 0; j < 3; j++) begin : g_ic
      mi3_div_lane u_div (
        .clk  (clk),
        .en   (rdy[4+LaneSt:5]),
        .cof  (c4[j*3+i]),
        .dmag (dmag),
        .dneg (dneg),
        .res  (qr[i*3+j])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      dline[0] <= {{(DetOutW-(DetW-32)){det[DetW-1]}}, det[DetW-1:32]};
      zline[0] <= zero;
    end
    for (int k = 1; k < LaneSt; k++) begin
      if (rdy[5+k]) begin
        dline[k] <= dline[k-1];
        zline[k] <= zline[k-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      inv_next[j] = zline[LaneSt-1] ? '0 : quot_sat(qr[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NumSt]) begin
      inv00 <= inv_next[0]; inv01 <= inv_next[1]; inv02 <= inv_next[2];
      inv10 <= inv_next[3]; inv11 <= inv_next[4]; inv12 <= inv_next[5];
      inv20 <= inv_next[6]; inv21 <= inv_next[7]; inv22 <= inv_next[8];
      determinant <= zline[LaneSt-1] ? '0 : dline[LaneSt-1];
      singular    <= zline[LaneSt-1];
    end
  end

`ifndef NO_ASSERTIONS
  a_no_stall_through: assert property (@(posedge clk) disable iff (rst)
    !inv_stall |-> !mat_stall) else $error("input stalled with free output");
  a_singular_det: assert property (@(posedge clk) disable iff (rst)
    inv_valid && singular |-> determinant == '0) else $error("singular with nonzero det");
  a_singular_inv: assert property (@(posedge clk) disable iff (rst)
    inv_valid && singular |-> inv00 == '0 && inv11 == '0 && inv22 == '0)
    else $error("singular with nonzero inverse");
`endif

endmodule

// ----- sim/tb_matrix3_inverse_top.sv -----
// Testbench for the 3x3 matrix inverse: directed and random matrices checked against a predictor.
`timescale 1ns / 1ps
module tb_matrix3_inverse_top;
  import mi3_pkg::*;

  typedef struct {
    logic signed [23:0] inv [9];
    logic signed [47:0] det;
    logic               sing;
  } inv_res_t;

  typedef struct {
    logic signed [23:0] m [9];
    logic               known;
    inv_res_t           res;
  } mat_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic mat_valid = 1'b0;
  logic mat_stall;
  elem_t a00 = '0, a01 = '0, a02 = '0, a10 = '0, a11 = '0, a12 = '0;
  elem_t a20 = '0, a21 = '0, a22 = '0;
  logic inv_valid;
  logic inv_stall = 1'b0;
  elem_t inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  logic signed [DetOutW-1:0] determinant;
  logic singular;

  matrix3_inverse_top dut (.*);

  inv_res_t inv_expected [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic inv_res_t inverse_of(logic signed [23:0] m [9]);
    inv_res_t r;
    logic signed [48:0] cof [9];
    logic signed [47:0] mi;
    logic signed [72:0] d;
    logic signed [72:0] dmag;
    logic signed [82:0] num;
    logic signed [82:0] q;
    int r0, r1, c0, c1;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        r0 = i > 0 ? 0 : 1; r1 = i < 2 ? 2 : 1;
        c0 = j > 0 ? 0 : 1; c1 = j < 2 ? 2 : 1;
        mi = 48'(m[r0*3+c0] * m[r1*3+c1]) - 48'(m[r0*3+c1] * m[r1*3+c0]);
        cof[i*3+j] = ((i + j) & 1) ? -49'(mi) : 49'(mi);
      end
    d = 73'(m[0]) * 73'(cof[0]) + 73'(m[1]) * 73'(cof[1]) + 73'(m[2]) * 73'(cof[2]);
    r.sing = (d == 0);
    r.det = r.sing ? '0 : 48'(d >>> 32);
    dmag = d < 0 ? -d : d;
    for (int i = 0; i < 9; i++) begin
      if (r.sing) r.inv[i] = '0;
      else begin
        num = 83'(cof[(i%3)*3 + i/3]) <<< 32;
        q = num / 83'(dmag);
        if (d < 0) q = -q;
        if (q > 83'sd8388607) q = 83'sd8388607;
        if (q < -83'sd8388608) q = -83'sd8388608;
        r.inv[i] = 24'(q);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    inv_res_t w;
    logic signed [23:0] g [9];
    if (!rst && inv_valid && !inv_stall) begin
      g = '{inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22};
      if (inv_expected.size() == 0) report_mismatch("unexpected item", 0, 0);
      else begin
        w = inv_expected.pop_front();
        for (int i = 0; i < 9; i++)
          if (g[i] !== w.inv[i]) report_mismatch($sformatf("inv%0d", i), g[i], w.inv[i]);
        if (determinant !== w.det) report_mismatch("determinant", determinant, w.det);
        if (singular !== w.sing) report_mismatch("singular", singular, w.sing);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) inv_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_matrix(logic signed [23:0] m [9], inv_res_t want);
    while ($urandom_range(99) < idle_pct) begin
      mat_valid <= 1'b0;
      @(negedge clk);
    end
    {a00, a01, a02, a10, a11, a12, a20, a21, a22} <=
      {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    mat_valid <= 1'b1;
    inv_expected.push_back(want);
    do @(posedge clk); while (mat_stall);
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] rand_elem(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(131072)) - 65536);
      2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      default: return 24'($signed($urandom_range(8)) - 4);
    endcase
  endfunction

  initial begin
    mat_row_t rows [$];
    mat_row_t rw;
    logic signed [23:0] m [9];
    inv_res_t z;
    int mode, guard;
    localparam logic signed [23:0] ONE = 24'sh010000;
    localparam logic signed [23:0] MX = 24'sh7FFFFF;
    localparam logic signed [23:0] MN = 24'sh800000;

    z.inv = '{default: '0}; z.det = '0; z.sing = 1'b1;
    // zero matrix and repeated rows are singular
    rw.known = 1; rw.res = z;
    rw.m = '{default: '0}; rows.push_back(rw);
    rw.m = '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE}; rows.push_back(rw);
    rw.m = '{default: MN}; rows.push_back(rw);
    rw.m = '{default: MX}; rows.push_back(rw);
    // identity: inverse is identity, det 1.0
    rw.m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    rw.res.inv = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    rw.res.det = 48'sd65536; rw.res.sing = 0; rows.push_back(rw);
    // -identity
    rw.m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};
    rw.res.inv = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};
    rw.res.det = -48'sd65536; rows.push_back(rw);
    // tiny diagonal: saturation
    rw.m = '{24'sd1, 0, 0, 0, 24'sd1, 0, 0, 0, 24'sd1};
    rw.res.inv = '{MX, 0, 0, 0, MX, 0, 0, 0, MX};
    rw.res.det = 48'sd0; rows.push_back(rw);
    rw.m = '{-24'sd1, 0, 0, 0, -24'sd1, 0, 0, 0, -24'sd1};
    rw.res.inv = '{MN, 0, 0, 0, MN, 0, 0, 0, MN};
    rw.res.det = -48'sd1; rows.push_back(rw);
    rw.known = 0;
    rw.m = '{MX, 0, 0, 0, MX, 0, 0, 0, MX}; rows.push_back(rw);
    rw.m = '{MN, 0, 0, 0, MN, 0, 0, 0, MN}; rows.push_back(rw);
    rw.m = '{MN, MX, 0, MX, MN, MX, 0, MX, MN}; rows.push_back(rw);
    rw.m = '{MX, MN, MX, MN, MX, MX, MX, MX, MN}; rows.push_back(rw);
    rw.m = '{ONE, 24'(2*ONE), 24'(3*ONE), 0, ONE, 24'(4*ONE), 24'(5*ONE), 24'(6*ONE), 0};
    rows.push_back(rw);
    rw.m = '{0, ONE, 0, ONE, 0, 0, 0, 0, ONE}; rows.push_back(rw);
    rw.m = '{24'sd3, 24'sd1, 0, 24'sd1, 24'sd3, 0, 0, 0, 24'sd2}; rows.push_back(rw);
    rw.m = '{24'sh555555, 24'shAAAAAA, 24'sh123456, 24'shFEDCBA, 24'sh0F0F0F,
             24'shF0F0F0, 24'sh7F0001, 24'sh80FFFF, 24'sh3C3C3C}; rows.push_back(rw);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[k]) send_matrix(rows[k].m, rows[k].known ? rows[k].res : inverse_of(rows[k].m));

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin idle_pct = 85; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 85; end
        3: begin idle_pct = 6; stall_pct = 6; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (int n = 0; n < 307; n++) begin
        mode = $urandom_range(3);
        for (int i = 0; i < 9; i++) m[i] = rand_elem($urandom_range(4) == 0 ? $urandom_range(3) : mode);
        // occasionally force a singular matrix by copying a row or a column
        if ($urandom_range(9) == 0) for (int i = 0; i < 3; i++) m[6+i] = m[3+i];
        if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) m[i*3+2] = m[i*3];
        send_matrix(m, inverse_of(m));
      end
    end
    mat_valid <= 1'b0;

    guard = 0;
    while (inv_expected.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && inv_expected.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
